/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
// all checks are sampled on the rising edge of clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is ignored while rst is high
`define DRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that also holds during reset
`define DRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/drq_pkg.sv */
// ----------------------------------------------------------------------------
// drq_pkg
// Types and codes shared by the dedup request queue controller and datapath.
// ----------------------------------------------------------------------------
package drq_pkg;

  localparam int FLOOR_W = 8;
  localparam int OCC_W   = 5;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_HEAD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
    logic head_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* hw/rtl/drq_ctrl.sv */
// ----------------------------------------------------------------------------
// drq_ctrl
// Sequencer for the dedup request queue: accept, scan, update, head read, result.
// ----------------------------------------------------------------------------
module drq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         op,
  input  drq_pkg::ctrl_sts_t sts,
  output logic               in_ready,
  output drq_pkg::ctrl_cmd_t cmd
);

  drq_pkg::state_t state;
  drq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      drq_pkg::S_IDLE: begin
        if (in_valid) begin
          // only an enqueue needs the duplicate search
          if (drq_pkg::op_t'(op) == drq_pkg::OP_ENQ) begin
            state_next = drq_pkg::S_SCAN;
          end else begin
            state_next = drq_pkg::S_EXEC;
          end
        end
      end
      drq_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_next = drq_pkg::S_EXEC;
        end
      end
      drq_pkg::S_EXEC: begin
        state_next = drq_pkg::S_HEAD;
      end
      drq_pkg::S_HEAD: begin
        state_next = drq_pkg::S_RESULT;
      end
      drq_pkg::S_RESULT: begin
        if (sts.out_free) begin
          state_next = drq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = drq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      drq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      drq_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      drq_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      drq_pkg::S_HEAD: begin
        cmd.head_rd = 1'b1;
      end
      drq_pkg::S_RESULT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/drq_datapath.sv */
// ----------------------------------------------------------------------------
// drq_datapath
// Ring store, head and fill pointers, serial duplicate compare, result register.
// ----------------------------------------------------------------------------
module drq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int FLOOR_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  drq_pkg::ctrl_cmd_t           cmd,
  output drq_pkg::ctrl_sts_t           sts,
  input  logic [1:0]                   op,
  input  logic [drq_pkg::FLOOR_W-1:0]  floor_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [drq_pkg::FLOOR_W-1:0]  head_floor,
  output logic                         head_valid,
  output logic [drq_pkg::OCC_W-1:0]    occupancy
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int VW = (FLOOR_BITS > drq_pkg::FLOOR_W) ? FLOOR_BITS : drq_pkg::FLOOR_W;
  localparam int OW = (CW > drq_pkg::OCC_W) ? CW : drq_pkg::OCC_W;

  logic [FLOOR_BITS-1:0] mem [QUEUE_DEPTH];
  logic [FLOOR_BITS-1:0] rd_data;
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  logic [CW-1:0]         scan_idx;
  logic                  pend;
  logic                  dup;
  drq_pkg::op_t          op_q;
  logic [FLOOR_BITS-1:0] val_q;
  drq_pkg::status_t      st_q;
  drq_pkg::status_t      status_q;

  logic [VW-1:0]         in_ext;
  logic [VW-1:0]         head_ext;
  logic [OW-1:0]         occ_ext;
  logic                  issue;
  logic                  found;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  is_full;
  logic                  is_empty;

  // slot at a given distance behind the head, wrapping at the depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(off);
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_ext   = VW'(floor_value);
  assign is_full  = (count == CW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  assign issue   = cmd.scan && (scan_idx != count);
  assign found   = pend && (rd_data == val_q);
  assign rd_en   = issue || cmd.head_rd;
  assign rd_addr = cmd.scan ? slot_of(head, scan_idx) : head;
  assign wr_en   = cmd.exec && (op_q == drq_pkg::OP_ENQ) && !dup && !is_full;
  assign wr_addr = slot_of(head, count);

  assign sts.scan_done = found || (scan_idx == count);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // request capture and status of the update step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= drq_pkg::op_t'(op);
      val_q <= in_ext[FLOOR_BITS-1:0];
    end
    if (cmd.exec) begin
      case (op_q)
        drq_pkg::OP_ENQ: begin
          if (dup) begin
            st_q <= drq_pkg::ST_DUP;
          end else if (is_full) begin
            st_q <= drq_pkg::ST_FULL;
          end else begin
            st_q <= drq_pkg::ST_OK;
          end
        end
        drq_pkg::OP_DEQ: begin
          st_q <= is_empty ? drq_pkg::ST_EMPTY : drq_pkg::ST_OK;
        end
        default: begin
          st_q <= drq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      scan_idx <= '0;
      pend     <= 1'b0;
      dup      <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        pend     <= 1'b0;
        dup      <= 1'b0;
      end
      if (cmd.scan) begin
        // compare comes in the cycle after the read issue
        pend <= issue;
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (found) begin
          dup <= 1'b1;
        end
      end
      if (wr_en) begin
        count <= count + 1'b1;
      end
      if (cmd.exec && (op_q == drq_pkg::OP_DEQ) && !is_empty) begin
        head  <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

  assign head_ext = VW'(rd_data);
  assign occ_ext  = OW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_q   <= st_q;
      head_floor <= is_empty ? '0 : head_ext[drq_pkg::FLOOR_W-1:0];
      head_valid <= !is_empty;
      occupancy  <= occ_ext[drq_pkg::OCC_W-1:0];
    end
  end

  assign status = status_q;

endmodule

/* hw/rtl/dedup_ring_request_queue_top.sv */
// ----------------------------------------------------------------------------
// dedup_ring_request_queue_top
// Ring FIFO of floor requests that drops duplicates, with serial search.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one request: op (enqueue, dequeue,
// peek; code 3 acts as peek) and floor_value. Output channel out_valid/out_ready
// carries one result per request: status, head_floor, head_valid, occupancy.
// One request is in flight at a time. in_ready is high only while the
// sequencer is idle. An enqueue reads the occupied entries one per cycle
// through the single read port of the store, oldest first, and stops at the
// first match, so an early match ends the search sooner. Dequeue and peek
// skip the search. The result sits in an output register, so the next
// request can be taken while it waits; if the receiver stalls, the following
// request finishes and then holds until the register frees. Synchronous
// reset empties the queue (head and fill count to zero) and drops any pending
// result; the store itself is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dedup_ring_request_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int FLOOR_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [drq_pkg::FLOOR_W-1:0]  floor_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [drq_pkg::FLOOR_W-1:0]  head_floor,
  output logic                         head_valid,
  output logic [drq_pkg::OCC_W-1:0]    occupancy
);

  drq_pkg::ctrl_cmd_t cmd;
  drq_pkg::ctrl_sts_t sts;

  drq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  drq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FLOOR_BITS  (FLOOR_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .floor_value (floor_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .head_floor  (head_floor),
    .head_valid  (head_valid),
    .occupancy   (occupancy)
  );

  `DRQ_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "request taken while busy")
  `DRQ_ASSERT(a_empty_head_zero, (out_valid && !head_valid) |-> (head_floor == '0), "empty queue shows a head")
  `DRQ_ASSERT(a_empty_reject, (out_valid && (status == drq_pkg::ST_EMPTY)) |-> !head_valid, "empty reject with entries")
  `DRQ_ASSERT(a_full_reject, (out_valid && (status == drq_pkg::ST_FULL)) |-> head_valid, "full reject with no entries")

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the duplicate-suppressing floor request queue. A
// scoreboard keeps its own ring of floors, predicts status, head and occupancy
// for every accepted request and checks each result in order. Directed
// requests cover empty, full, duplicate and unused-op cases, then biased
// random traffic fills, drains and wraps the ring under bursty sender timing
// and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RING_DEPTH   = 16;
  localparam int          RANDOM_REQS  = 1250;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct {
    drq_pkg::status_t                status;
    logic [drq_pkg::FLOOR_W-1:0]     head_floor;
    logic                            head_valid;
    logic [drq_pkg::OCC_W-1:0]       occupancy;
  } floor_result_t;

  class floor_queue_scoreboard;
    logic [drq_pkg::FLOOR_W-1:0] slots [RING_DEPTH];
    logic [3:0]                  head_idx;
    logic [drq_pkg::OCC_W-1:0]   fill;
    floor_result_t               expected_results [$];
    int                          errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      head_idx = '0;
      fill     = '0;
      errors   = 0;
    endfunction

    function void note_request(logic [1:0] req_op,
                               logic [drq_pkg::FLOOR_W-1:0] req_floor);
      floor_result_t want;
      logic          hit;
      logic [3:0]    pos;
      want.status = drq_pkg::ST_OK;
      hit = 1'b0;
      case (drq_pkg::op_t'(req_op))
        drq_pkg::OP_ENQ: begin
          // oldest entry first, any match makes it a duplicate
          for (int i = 0; i < fill; i++) begin
            pos = head_idx + 4'(i);
            if (slots[pos] == req_floor) hit = 1'b1;
          end
          if (hit) begin
            want.status = drq_pkg::ST_DUP;
          end else if (fill == RING_DEPTH) begin
            want.status = drq_pkg::ST_FULL;
          end else begin
            pos = head_idx + fill[3:0];
            slots[pos] = req_floor;
            fill++;
          end
        end
        drq_pkg::OP_DEQ: begin
          if (fill == 0) begin
            want.status = drq_pkg::ST_EMPTY;
          end else begin
            head_idx++;
            fill--;
          end
        end
        default: ;  // peek and the unused code change nothing
      endcase
      want.head_valid = (fill != 0);
      want.head_floor = (fill != 0) ? slots[head_idx] : '0;
      want.occupancy  = fill;
      expected_results.push_back(want);
    endfunction

    function void check_result(logic [1:0] got_st, logic [drq_pkg::FLOOR_W-1:0] got_head,
                               logic got_hv, logic [drq_pkg::OCC_W-1:0] got_occ);
      floor_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d head %0d valid %0d occupancy %0d",
                 $time, got_st, got_head, got_hv, got_occ);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got_st !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, got_st);
        errors++;
      end
      if (got_head !== want.head_floor) begin
        $display("%0t: head_floor mismatch, expected %0d, actual %0d",
                 $time, want.head_floor, got_head);
        errors++;
      end
      if (got_hv !== want.head_valid) begin
        $display("%0t: head_valid mismatch, expected %0d, actual %0d",
                 $time, want.head_valid, got_hv);
        errors++;
      end
      if (got_occ !== want.occupancy) begin
        $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                 $time, want.occupancy, got_occ);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  logic [1:0]                  op          = drq_pkg::OP_PEEK;
  logic [drq_pkg::FLOOR_W-1:0] floor_value = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  logic [1:0]                  status;
  logic [drq_pkg::FLOOR_W-1:0] head_floor;
  logic                        head_valid;
  logic [drq_pkg::OCC_W-1:0]   occupancy;

  floor_queue_scoreboard sb = new();

  int cycles    = 0;
  int burst_left = 0;
  int rx_mode   = 0;
  int rx_run    = 0;

  dedup_ring_request_queue_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .floor_value (floor_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .head_floor  (head_floor),
    .head_valid  (head_valid),
    .occupancy   (occupancy)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: runs of always-ready, coin-flip, and mostly-stalled
  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_run  <= $urandom_range(4, 60);
    end else begin
      rx_run <= rx_run - 1;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_run % 9 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(status, head_floor, head_valid, occupancy);
      if (in_valid && in_ready) sb.note_request(op, floor_value);
    end
  end

  task automatic send_request(input logic [1:0] req_op,
                              input logic [drq_pkg::FLOOR_W-1:0] req_floor);
    in_valid    <= 1'b1;
    op          <= req_op;
    floor_value <= req_floor;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender bursts: back-to-back requests, then a random gap
  task automatic issue(input logic [1:0] req_op, input logic [drq_pkg::FLOOR_W-1:0] req_floor);
    send_request(req_op, req_floor);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  initial begin
    int                          enq_pct;
    int                          r;
    logic [1:0]                  req_op;
    logic [drq_pkg::FLOOR_W-1:0] req_floor;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue corner cases
    issue(drq_pkg::OP_PEEK, 8'hA5);
    issue(drq_pkg::OP_DEQ, 8'h5A);
    issue(OP_UNUSED, 8'hFF);
    issue(drq_pkg::OP_ENQ, 8'h00);
    issue(drq_pkg::OP_ENQ, 8'h00);
    issue(drq_pkg::OP_DEQ, 8'h00);
    // fill to the top, then a new floor and a duplicate while full
    for (int i = 0; i < RING_DEPTH; i++) issue(drq_pkg::OP_ENQ, 8'hFF - 8'(i * 17));
    issue(drq_pkg::OP_ENQ, 8'h80);
    issue(drq_pkg::OP_ENQ, 8'h00);

    enq_pct = 50;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      // phases that lean toward filling, draining or neither
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 85;
          1:       enq_pct = 20;
          default: enq_pct = 50;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < enq_pct) req_op = drq_pkg::OP_ENQ;
      else if (r < enq_pct + (100 - enq_pct) * 3 / 4) req_op = drq_pkg::OP_DEQ;
      else if ($urandom_range(0, 3) == 0) req_op = OP_UNUSED;
      else req_op = drq_pkg::OP_PEEK;
      // a small pool of floors keeps duplicates frequent
      if ($urandom_range(0, 3) == 0) req_floor = 8'($urandom_range(0, 255));
      else req_floor = 8'($urandom_range(0, 19));
      issue(req_op, req_floor);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
